>>> src/snfcs_pkg.sv
// shared types, codes and helpers for the spi nor flash command sequencer
package snfcs_pkg;

    localparam int PAGE_BYTES_DEF   = 256;
    localparam int SECTOR_BYTES_DEF = 4096;
    localparam int MAX_RES          = 8;
    localparam int CNT_W            = $clog2(MAX_RES + 1);
    localparam logic [7:0] ERASE_OP_RST = 8'h20;

    localparam logic [7:0] OP_PROG  = 8'h02;
    localparam logic [7:0] OP_READ  = 8'h03;
    localparam logic [7:0] OP_WDIS  = 8'h04;
    localparam logic [7:0] OP_RDSR  = 8'h05;
    localparam logic [7:0] OP_WEN   = 8'h06;
    localparam logic [7:0] OP_ID    = 8'h90;
    localparam logic [7:0] OP_DUMMY = 8'hFF;

    typedef enum logic [2:0] {
        REQ_READ  = 3'd0,
        REQ_PROG  = 3'd1,
        REQ_ERASE = 3'd2,
        REQ_ID    = 3'd3,
        REQ_REPLY = 3'd4,
        REQ_DATA  = 3'd5
    } t_req;

    typedef enum logic [2:0] {
        OK_SPI  = 3'd0,
        OK_HOST = 3'd1,
        OK_ID   = 3'd2,
        OK_DONE = 3'd3,
        OK_ERR  = 3'd4
    } t_okind;

    typedef enum logic [6:0] {
        ST_IDLE       = 7'b0000001,
        ST_READ       = 7'b0000010,
        ST_PROG_DATA  = 7'b0000100,
        ST_PROG_STAT  = 7'b0001000,
        ST_ERASE_STAT = 7'b0010000,
        ST_ID_DATA    = 7'b0100000,
        ST_ID_STAT    = 7'b1000000
    } t_state;

    typedef struct packed {
        t_okind      kind;
        logic [7:0]  spi;
        logic        fe;
        logic        wr;
        logic [7:0]  host;
        logic [15:0] id;
    } t_res;

    typedef struct packed {
        logic [CNT_W-1:0]     count;
        t_res [MAX_RES-1:0]   ent;
    } t_batch;

    function automatic t_res f_spi(logic [7:0] b, logic fe, logic wr);
        t_res r;
        r      = '0;
        r.kind = OK_SPI;
        r.spi  = b;
        r.fe   = fe;
        r.wr   = wr;
        return r;
    endfunction

    function automatic t_res f_mark(t_okind k);
        t_res r;
        r      = '0;
        r.kind = k;
        return r;
    endfunction

    function automatic t_res f_host(logic [7:0] b);
        t_res r;
        r      = '0;
        r.kind = OK_HOST;
        r.host = b;
        return r;
    endfunction

    function automatic t_res f_idres(logic [15:0] v);
        t_res r;
        r      = '0;
        r.kind = OK_ID;
        r.id   = v;
        return r;
    endfunction

endpackage

>>> src/snfcs_core.sv
// job state registers and the per-beat step logic that builds the result batch
module snfcs_core #(
    parameter int PAGE_BYTES   = snfcs_pkg::PAGE_BYTES_DEF,
    parameter int SECTOR_BYTES = snfcs_pkg::SECTOR_BYTES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_valid,
    input  logic [7:0]          i_cfg_data,
    input  logic                i_acc,
    input  logic [2:0]          i_req_type,
    input  logic [23:0]         i_addr,
    input  logic [23:0]         i_cnt,
    input  logic [7:0]          i_byte,
    output snfcs_pkg::t_batch   o_batch
);
    import snfcs_pkg::*;

    // page size is a power of two
    localparam int PW = $clog2(PAGE_BYTES);
    localparam int CW = $clog2(PAGE_BYTES + 1);
    localparam logic [23:0] SEC24 = 24'(SECTOR_BYTES);

    t_state        r_state, n_state;
    logic [23:0]   r_addr, n_addr;
    logic [23:0]   r_rem, n_rem;
    logic [CW-1:0] r_chunk, n_chunk;
    logic [7:0]    r_idh, n_idh;
    logic [7:0]    r_eop;

    t_batch        n_batch;
    logic [23:0]   addr_inc, addr_sec, rem_dec, rem_sec;
    logic [CW-1:0] chunk_dec;

    function automatic logic [CW-1:0] f_chunk(logic [23:0] a, logic [23:0] rem);
        logic [CW-1:0] room;
        room = CW'(PAGE_BYTES) - CW'(a[PW-1:0]);
        return (rem < 24'(room)) ? rem[CW-1:0] : room;
    endfunction

    always_comb begin
        addr_inc  = r_addr + 24'd1;
        addr_sec  = r_addr + SEC24;
        rem_dec   = (r_rem != 24'd0) ? r_rem - 24'd1 : r_rem;
        rem_sec   = (r_rem > SEC24) ? r_rem - SEC24 : 24'd0;
        chunk_dec = r_chunk - CW'(1);
    end

    always_comb begin
        n_state = r_state;
        n_addr  = r_addr;
        n_rem   = r_rem;
        n_chunk = r_chunk;
        n_idh   = r_idh;
        n_batch = '0;
        if (i_acc) begin
            if (i_req_type <= REQ_ID && r_state != ST_IDLE) begin
                n_batch.ent[0] = f_mark(OK_ERR);
                n_batch.count  = CNT_W'(1);
            end else begin
                case (t_req'(i_req_type))
                    REQ_READ: begin
                        n_addr = i_addr;
                        n_rem  = i_cnt;
                        n_batch.ent[0] = f_spi(OP_READ, 1'b0, 1'b0);
                        n_batch.ent[1] = f_spi(i_addr[23:16], 1'b0, 1'b0);
                        n_batch.ent[2] = f_spi(i_addr[15:8], 1'b0, 1'b0);
                        n_batch.ent[3] = f_spi(i_addr[7:0], i_cnt == 24'd0, 1'b0);
                        n_batch.count  = CNT_W'(5);
                        if (i_cnt == 24'd0) begin
                            n_batch.ent[4] = f_mark(OK_DONE);
                        end else begin
                            n_batch.ent[4] = f_spi(OP_DUMMY, i_cnt == 24'd1, 1'b1);
                            n_state = ST_READ;
                        end
                    end
                    REQ_PROG: begin
                        n_addr = i_addr;
                        n_rem  = i_cnt;
                        if (i_cnt == 24'd0) begin
                            n_batch.ent[0] = f_mark(OK_DONE);
                            n_batch.count  = CNT_W'(1);
                        end else begin
                            n_chunk = f_chunk(i_addr, i_cnt);
                            n_batch.ent[0] = f_spi(OP_WEN, 1'b1, 1'b0);
                            n_batch.ent[1] = f_spi(OP_PROG, 1'b0, 1'b0);
                            n_batch.ent[2] = f_spi(i_addr[23:16], 1'b0, 1'b0);
                            n_batch.ent[3] = f_spi(i_addr[15:8], 1'b0, 1'b0);
                            n_batch.ent[4] = f_spi(i_addr[7:0], 1'b0, 1'b0);
                            n_batch.count  = CNT_W'(5);
                            n_state = ST_PROG_DATA;
                        end
                    end
                    REQ_ERASE: begin
                        n_addr = i_addr;
                        n_rem  = i_cnt;
                        if (i_cnt == 24'd0) begin
                            n_batch.ent[0] = f_mark(OK_DONE);
                            n_batch.count  = CNT_W'(1);
                        end else begin
                            n_batch.ent[0] = f_spi(OP_WEN, 1'b1, 1'b0);
                            n_batch.ent[1] = f_spi(r_eop, 1'b0, 1'b0);
                            n_batch.ent[2] = f_spi(i_addr[23:16], 1'b0, 1'b0);
                            n_batch.ent[3] = f_spi(i_addr[15:8], 1'b0, 1'b0);
                            n_batch.ent[4] = f_spi(i_addr[7:0], 1'b1, 1'b0);
                            n_batch.ent[5] = f_spi(OP_RDSR, 1'b0, 1'b0);
                            n_batch.ent[6] = f_spi(OP_DUMMY, 1'b1, 1'b1);
                            n_batch.count  = CNT_W'(7);
                            n_state = ST_ERASE_STAT;
                        end
                    end
                    REQ_ID: begin
                        n_batch.ent[0] = f_spi(OP_ID, 1'b0, 1'b0);
                        n_batch.ent[1] = f_spi(8'h00, 1'b0, 1'b0);
                        n_batch.ent[2] = f_spi(8'h00, 1'b0, 1'b0);
                        n_batch.ent[3] = f_spi(8'h00, 1'b0, 1'b0);
                        n_batch.ent[4] = f_spi(OP_DUMMY, 1'b0, 1'b1);
                        n_batch.count  = CNT_W'(5);
                        n_state = ST_ID_DATA;
                    end
                    REQ_REPLY: begin
                        case (r_state)
                            ST_READ: begin
                                n_addr = addr_inc;
                                n_rem  = rem_dec;
                                n_batch.ent[0] = f_host(i_byte);
                                n_batch.count  = CNT_W'(2);
                                if (rem_dec != 24'd0) begin
                                    n_batch.ent[1] = f_spi(OP_DUMMY, rem_dec == 24'd1, 1'b1);
                                end else begin
                                    n_batch.ent[1] = f_mark(OK_DONE);
                                    n_state = ST_IDLE;
                                end
                            end
                            ST_ID_DATA: begin
                                n_idh = i_byte;
                                n_batch.ent[0] = f_spi(OP_DUMMY, 1'b1, 1'b1);
                                n_batch.count  = CNT_W'(1);
                                n_state = ST_ID_STAT;
                            end
                            ST_ID_STAT: begin
                                n_batch.ent[0] = f_idres({r_idh, i_byte});
                                n_batch.ent[1] = f_mark(OK_DONE);
                                n_batch.count  = CNT_W'(2);
                                n_state = ST_IDLE;
                            end
                            ST_PROG_STAT: begin
                                if (i_byte[0]) begin
                                    n_batch.ent[0] = f_spi(OP_RDSR, 1'b0, 1'b0);
                                    n_batch.ent[1] = f_spi(OP_DUMMY, 1'b1, 1'b1);
                                    n_batch.count  = CNT_W'(2);
                                end else if (r_rem != 24'd0) begin
                                    n_chunk = f_chunk(r_addr, r_rem);
                                    n_batch.ent[0] = f_spi(OP_WDIS, 1'b1, 1'b0);
                                    n_batch.ent[1] = f_spi(OP_WEN, 1'b1, 1'b0);
                                    n_batch.ent[2] = f_spi(OP_PROG, 1'b0, 1'b0);
                                    n_batch.ent[3] = f_spi(r_addr[23:16], 1'b0, 1'b0);
                                    n_batch.ent[4] = f_spi(r_addr[15:8], 1'b0, 1'b0);
                                    n_batch.ent[5] = f_spi(r_addr[7:0], 1'b0, 1'b0);
                                    n_batch.count  = CNT_W'(6);
                                    n_state = ST_PROG_DATA;
                                end else begin
                                    n_batch.ent[0] = f_spi(OP_WDIS, 1'b1, 1'b0);
                                    n_batch.ent[1] = f_mark(OK_DONE);
                                    n_batch.count  = CNT_W'(2);
                                    n_state = ST_IDLE;
                                end
                            end
                            ST_ERASE_STAT: begin
                                if (i_byte[0]) begin
                                    n_batch.ent[0] = f_spi(OP_RDSR, 1'b0, 1'b0);
                                    n_batch.ent[1] = f_spi(OP_DUMMY, 1'b1, 1'b1);
                                    n_batch.count  = CNT_W'(2);
                                end else begin
                                    n_rem  = rem_sec;
                                    n_addr = addr_sec;
                                    if (rem_sec != 24'd0) begin
                                        n_batch.ent[0] = f_spi(OP_WEN, 1'b1, 1'b0);
                                        n_batch.ent[1] = f_spi(r_eop, 1'b0, 1'b0);
                                        n_batch.ent[2] = f_spi(addr_sec[23:16], 1'b0, 1'b0);
                                        n_batch.ent[3] = f_spi(addr_sec[15:8], 1'b0, 1'b0);
                                        n_batch.ent[4] = f_spi(addr_sec[7:0], 1'b1, 1'b0);
                                        n_batch.ent[5] = f_spi(OP_RDSR, 1'b0, 1'b0);
                                        n_batch.ent[6] = f_spi(OP_DUMMY, 1'b1, 1'b1);
                                        n_batch.count  = CNT_W'(7);
                                    end else begin
                                        n_batch.ent[0] = f_spi(OP_WDIS, 1'b1, 1'b0);
                                        n_batch.ent[1] = f_mark(OK_DONE);
                                        n_batch.count  = CNT_W'(2);
                                        n_state = ST_IDLE;
                                    end
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                    REQ_DATA: begin
                        if (r_state == ST_PROG_DATA && r_chunk != '0) begin
                            n_chunk = chunk_dec;
                            n_rem   = rem_dec;
                            n_addr  = addr_inc;
                            n_batch.ent[0] = f_spi(i_byte, chunk_dec == '0, 1'b0);
                            n_batch.count  = CNT_W'(1);
                            if (chunk_dec == '0) begin
                                n_batch.ent[1] = f_spi(OP_RDSR, 1'b0, 1'b0);
                                n_batch.ent[2] = f_spi(OP_DUMMY, 1'b1, 1'b1);
                                n_batch.count  = CNT_W'(3);
                                n_state = ST_PROG_STAT;
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_addr  <= '0;
            r_rem   <= '0;
            r_chunk <= '0;
            r_idh   <= '0;
            r_eop   <= ERASE_OP_RST;
        end else begin
            r_state <= n_state;
            r_addr  <= n_addr;
            r_rem   <= n_rem;
            r_chunk <= n_chunk;
            r_idh   <= n_idh;
            if (i_cfg_valid) begin
                r_eop <= i_cfg_data;
            end
        end
    end

    assign o_batch = n_batch;

endmodule

>>> src/snfcs_outq.sv
// result batch register that hands out one result beat per cycle while i_tready is high
module snfcs_outq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  snfcs_pkg::t_batch   i_batch,
    input  logic                i_tready,
    output logic                o_can_load,
    output logic                o_tvalid,
    output logic                o_tlast,
    output snfcs_pkg::t_res     o_res
);
    import snfcs_pkg::*;

    logic [CNT_W-1:0]   r_cnt, n_cnt;
    t_res [MAX_RES-1:0] r_q, n_q;
    logic               take;

    always_comb begin
        take  = (r_cnt != '0) && i_tready;
        n_cnt = r_cnt;
        n_q   = r_q;
        if (i_load) begin
            n_cnt = i_batch.count;
            n_q   = i_batch.ent;
        end else if (take) begin
            n_cnt = r_cnt - CNT_W'(1);
            for (int i = 0; i < MAX_RES - 1; i++) begin
                n_q[i] = r_q[i+1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q <= n_q;
    end

    assign o_can_load = (r_cnt == '0) || (r_cnt == CNT_W'(1) && i_tready);
    assign o_tvalid   = (r_cnt != '0);
    assign o_tlast    = (r_cnt == CNT_W'(1));
    assign o_res      = r_q[0];

endmodule

>>> src/spi_nor_flash_command_sequencer.sv
// top level of the spi nor flash command sequencer
//
// s_axis carries requests, program data bytes and flash reply bytes; the
// request type rides in s_axis_tuser. m_axis carries results: spi bytes to
// shift out (with frame end and reply-wanted marks), host read bytes, the
// id value and done / busy-error marks; the result kind rides in
// m_axis_tuser and tlast marks the final result of each input beat.
// i_cfg_data sets the sector erase opcode; the write is taken at once.
// The first result of an input beat appears in the cycle after the beat is
// accepted. Results leave at one per cycle while m_axis is ready, and a beat
// holds the output until all of its results are taken; a new input beat is
// taken while the last result of the previous one is being handed off, so
// back-to-back input runs at one beat per cycle when each beat yields at
// most one result and m_axis is ready. Throughput is set by the single
// result port draining the batch register.
// A stalled m_axis holds its beat and blocks s_axis until the batch drains.
// Reset empties the result queue, returns the job to idle and sets the
// erase opcode to 0x20.
module spi_nor_flash_command_sequencer #(
    parameter int PAGE_BYTES   = snfcs_pkg::PAGE_BYTES_DEF,
    parameter int SECTOR_BYTES = snfcs_pkg::SECTOR_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [55:0] s_axis_tdata,   // flash_addr, byte_count, data_byte
    input  logic [2:0]  s_axis_tuser,   // req_type
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // spi_byte, frame_end, want_reply, host_byte,
                                        // id_value, zero fill
    output logic [2:0]  m_axis_tuser,   // out_kind
    output logic        m_axis_tlast
);
    import snfcs_pkg::*;

    logic   can_load, acc;
    t_batch batch;
    t_res   res;

    assign acc           = s_axis_tvalid && can_load;
    assign s_axis_tready = can_load;
    assign o_cfg_ready   = 1'b1;

    snfcs_core #(
        .PAGE_BYTES   (PAGE_BYTES),
        .SECTOR_BYTES (SECTOR_BYTES)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_acc       (acc),
        .i_req_type  (s_axis_tuser),
        .i_addr      (s_axis_tdata[23:0]),
        .i_cnt       (s_axis_tdata[47:24]),
        .i_byte      (s_axis_tdata[55:48]),
        .o_batch     (batch)
    );

    snfcs_outq u_outq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (acc),
        .i_batch    (batch),
        .i_tready   (m_axis_tready),
        .o_can_load (can_load),
        .o_tvalid   (m_axis_tvalid),
        .o_tlast    (m_axis_tlast),
        .o_res      (res)
    );

    assign m_axis_tuser = res.kind;
    assign m_axis_tdata = {6'd0, res.id, res.host, res.wr, res.fe, res.spi};

endmodule

>>> src/snfcs_chk.sv
// port-level checks for the spi nor flash command sequencer
module snfcs_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata,
    input logic [2:0]  m_axis_tuser,
    input logic        m_axis_tlast
);
    import snfcs_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result beat changed while stalled");

    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    a_in_gate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready && m_axis_tvalid |-> m_axis_tlast && m_axis_tready)
        else $error("input taken while results still pending");

    a_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == OK_DONE || m_axis_tuser == OK_ERR)
            |-> m_axis_tlast)
        else $error("done or error beat not last");

endmodule

bind spi_nor_flash_command_sequencer snfcs_chk u_snfcs_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

>>> tb/testbench.sv
// self-checking testbench for the spi nor flash command sequencer: directed table, then random jobs
module testbench;
    import snfcs_pkg::*;

    localparam logic [2:0] REQ_SPARE6 = 3'd6;
    localparam logic [2:0] REQ_SPARE7 = 3'd7;
    localparam int QUIET_LIMIT = 2000;
    localparam int N_DIR       = 27;
    localparam int BUSY_PER_PHASE = 30;

    typedef enum logic [2:0] {
        JOB_IDLE, JOB_READ, JOB_PROG, JOB_ERASE, JOB_ID
    } t_job;

    typedef enum logic [1:0] {
        STEP_NONE, STEP_DATA, STEP_STATUS
    } t_step;

    typedef struct packed {
        t_okind      kind;
        logic [7:0]  spi;
        logic        fe;
        logic        wr;
        logic [7:0]  host;
        logic [15:0] id;
        logic        last;
    } t_flash_beat;

    typedef struct packed {
        logic [2:0]  req;
        logic [23:0] addr;
        logic [23:0] cnt;
        logic [7:0]  data;
        logic        typed;
        logic        has_res;
        t_okind      kind;
    } t_dir_row;

    logic        i_clk;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_valid   = 1'b0;
    logic        o_cfg_ready;
    logic [7:0]  i_cfg_data    = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata  = '0;   // flash_addr, byte_count, data_byte
    logic [2:0]  s_axis_tuser  = '0;   // req_type
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;         // spi_byte, frame_end, want_reply, host_byte, id_value, fill
    logic [2:0]  m_axis_tuser;         // out_kind
    logic        m_axis_tlast;

    t_flash_beat result_q [$];
    int          err_count     = 0;
    int          quiet_cycles  = 0;
    int          src_gap_pct   = 0;
    int          snk_stall_pct = 0;

    // predictor state
    logic [7:0]  erase_op   = ERASE_OP_RST;
    t_job        flash_job  = JOB_IDLE;
    t_step       flash_step = STEP_NONE;
    logic [23:0] cur_addr   = '0;
    logic [23:0] bytes_left = '0;
    logic [12:0] page_left  = '0;
    logic [7:0]  id_hi      = '0;

    t_dir_row dir_rows [N_DIR] = '{
        '{REQ_DATA,   24'h000000, 24'h000000, 8'hFF, 1'b1, 1'b0, OK_SPI},
        '{REQ_REPLY,  24'h000000, 24'h000000, 8'h00, 1'b1, 1'b0, OK_SPI},
        '{REQ_SPARE6, 24'hFFFFFF, 24'hFFFFFF, 8'hFF, 1'b1, 1'b0, OK_SPI},
        '{REQ_SPARE7, 24'h000000, 24'h000000, 8'h00, 1'b1, 1'b0, OK_SPI},
        '{REQ_PROG,   24'h123456, 24'h000000, 8'h00, 1'b1, 1'b1, OK_DONE},
        '{REQ_ERASE,  24'hFFFFFF, 24'h000000, 8'h00, 1'b1, 1'b1, OK_DONE},
        '{REQ_READ,   24'hFFFFFF, 24'h000000, 8'h00, 1'b0, 1'b0, OK_SPI},
        '{REQ_ID,     24'h000000, 24'h000000, 8'h00, 1'b0, 1'b0, OK_SPI},
        '{REQ_READ,   24'hFFFFFF, 24'hFFFFFF, 8'hFF, 1'b1, 1'b1, OK_ERR},
        '{REQ_REPLY,  24'h000000, 24'h000000, 8'hC2, 1'b0, 1'b0, OK_SPI},
        '{REQ_REPLY,  24'h000000, 24'h000000, 8'h00, 1'b0, 1'b0, OK_SPI},
        '{REQ_READ,   24'hFFFFFF, 24'h000002, 8'h00, 1'b0, 1'b0, OK_SPI},
        '{REQ_DATA,   24'h000000, 24'h000000, 8'h55, 1'b1, 1'b0, OK_SPI},
        '{REQ_REPLY,  24'h000000, 24'h000000, 8'hFF, 1'b0, 1'b0, OK_SPI},
        '{REQ_REPLY,  24'h000000, 24'h000000, 8'h00, 1'b0, 1'b0, OK_SPI},
        '{REQ_PROG,   24'hFFFFFE, 24'h000003, 8'h00, 1'b0, 1'b0, OK_SPI},
        '{REQ_REPLY,  24'h000000, 24'h000000, 8'h00, 1'b1, 1'b0, OK_SPI},
        '{REQ_DATA,   24'h000000, 24'h000000, 8'h00, 1'b0, 1'b0, OK_SPI},
        '{REQ_DATA,   24'h000000, 24'h000000, 8'hFF, 1'b0, 1'b0, OK_SPI},
        '{REQ_REPLY,  24'h000000, 24'h000000, 8'h01, 1'b0, 1'b0, OK_SPI},
        '{REQ_REPLY,  24'h000000, 24'h000000, 8'hFE, 1'b0, 1'b0, OK_SPI},
        '{REQ_DATA,   24'h000000, 24'h000000, 8'hA5, 1'b0, 1'b0, OK_SPI},
        '{REQ_REPLY,  24'h000000, 24'h000000, 8'h00, 1'b0, 1'b0, OK_SPI},
        '{REQ_ERASE,  24'hFFF000, 24'h001001, 8'h00, 1'b0, 1'b0, OK_SPI},
        '{REQ_REPLY,  24'h000000, 24'h000000, 8'h03, 1'b0, 1'b0, OK_SPI},
        '{REQ_REPLY,  24'h000000, 24'h000000, 8'h00, 1'b0, 1'b0, OK_SPI},
        '{REQ_REPLY,  24'h000000, 24'h000000, 8'h00, 1'b0, 1'b0, OK_SPI}
    };

    spi_nor_flash_command_sequencer uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= snk_stall_pct);
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    function automatic void emit(t_okind k, logic [7:0] s, logic fe, logic wr,
                                 logic [7:0] h, logic [15:0] idv);
        t_flash_beat e;
        e      = '0;
        e.kind = k;
        e.spi  = s;
        e.fe   = fe;
        e.wr   = wr;
        e.host = h;
        e.id   = idv;
        result_q.push_back(e);
    endfunction

    function automatic void emit_spi(logic [7:0] b, logic fe, logic wr);
        emit(OK_SPI, b, fe, wr, 8'h00, 16'h0000);
    endfunction

    function automatic void emit_addr(logic [23:0] a, logic fe);
        emit_spi(a[23:16], 1'b0, 1'b0);
        emit_spi(a[15:8], 1'b0, 1'b0);
        emit_spi(a[7:0], fe, 1'b0);
    endfunction

    function automatic void emit_poll();
        emit_spi(OP_RDSR, 1'b0, 1'b0);
        emit_spi(OP_DUMMY, 1'b1, 1'b1);
    endfunction

    function automatic void close_job();
        emit(OK_DONE, 8'h00, 1'b0, 1'b0, 8'h00, 16'h0000);
        flash_job  = JOB_IDLE;
        flash_step = STEP_NONE;
    endfunction

    function automatic void open_chunk();
        int room;
        room = PAGE_BYTES_DEF - int'(cur_addr % PAGE_BYTES_DEF);
        page_left = (int'(bytes_left) < room) ? 13'(bytes_left) : 13'(room);
        emit_spi(OP_WEN, 1'b1, 1'b0);
        emit_spi(OP_PROG, 1'b0, 1'b0);
        emit_addr(cur_addr, 1'b0);
        flash_step = STEP_DATA;
    endfunction

    function automatic void open_sector();
        emit_spi(OP_WEN, 1'b1, 1'b0);
        emit_spi(erase_op, 1'b0, 1'b0);
        emit_addr(cur_addr, 1'b1);
        emit_poll();
        flash_step = STEP_STATUS;
    endfunction

    // works out the result beats of one accepted input beat, returns their number
    function automatic int predict_flash(logic [2:0] rq, logic [23:0] ad, logic [23:0] ct,
                                         logic [7:0] b);
        int start_size;
        start_size = result_q.size();
        if (rq <= REQ_ID && flash_job != JOB_IDLE) begin
            emit(OK_ERR, 8'h00, 1'b0, 1'b0, 8'h00, 16'h0000);
        end else begin
            case (rq)
                REQ_READ: begin
                    cur_addr   = ad;
                    bytes_left = ct;
                    emit_spi(OP_READ, 1'b0, 1'b0);
                    emit_addr(ad, ct == 0);
                    if (ct == 0) begin
                        close_job();
                    end else begin
                        emit_spi(OP_DUMMY, ct == 1, 1'b1);
                        flash_job  = JOB_READ;
                        flash_step = STEP_DATA;
                    end
                end
                REQ_PROG: begin
                    cur_addr   = ad;
                    bytes_left = ct;
                    if (ct == 0) begin
                        close_job();
                    end else begin
                        flash_job = JOB_PROG;
                        open_chunk();
                    end
                end
                REQ_ERASE: begin
                    cur_addr   = ad;
                    bytes_left = ct;
                    if (ct == 0) begin
                        close_job();
                    end else begin
                        flash_job = JOB_ERASE;
                        open_sector();
                    end
                end
                REQ_ID: begin
                    emit_spi(OP_ID, 1'b0, 1'b0);
                    emit_addr(24'h000000, 1'b0);
                    emit_spi(OP_DUMMY, 1'b0, 1'b1);
                    flash_job  = JOB_ID;
                    flash_step = STEP_DATA;
                end
                REQ_REPLY: begin
                    if (flash_job == JOB_READ && flash_step == STEP_DATA) begin
                        emit(OK_HOST, 8'h00, 1'b0, 1'b0, b, 16'h0000);
                        cur_addr = cur_addr + 24'd1;
                        if (bytes_left != 0) bytes_left = bytes_left - 24'd1;
                        if (bytes_left != 0) emit_spi(OP_DUMMY, bytes_left == 1, 1'b1);
                        else close_job();
                    end else if (flash_job == JOB_ID && flash_step == STEP_DATA) begin
                        id_hi = b;
                        emit_spi(OP_DUMMY, 1'b1, 1'b1);
                        flash_step = STEP_STATUS;
                    end else if (flash_job == JOB_ID && flash_step == STEP_STATUS) begin
                        emit(OK_ID, 8'h00, 1'b0, 1'b0, 8'h00, {id_hi, b});
                        close_job();
                    end else if ((flash_job == JOB_PROG || flash_job == JOB_ERASE) &&
                                 flash_step == STEP_STATUS) begin
                        if (b[0]) begin
                            emit_poll();
                        end else if (flash_job == JOB_PROG) begin
                            emit_spi(OP_WDIS, 1'b1, 1'b0);
                            if (bytes_left != 0) open_chunk();
                            else close_job();
                        end else begin
                            bytes_left = (bytes_left > SECTOR_BYTES_DEF) ?
                                         24'(bytes_left - SECTOR_BYTES_DEF) : 24'd0;
                            cur_addr = cur_addr + 24'(SECTOR_BYTES_DEF);
                            if (bytes_left != 0) begin
                                open_sector();
                            end else begin
                                emit_spi(OP_WDIS, 1'b1, 1'b0);
                                close_job();
                            end
                        end
                    end
                end
                REQ_DATA: begin
                    if (flash_job == JOB_PROG && flash_step == STEP_DATA && page_left != 0) begin
                        page_left = page_left - 13'd1;
                        if (bytes_left != 0) bytes_left = bytes_left - 24'd1;
                        cur_addr = cur_addr + 24'd1;
                        emit_spi(b, page_left == 0, 1'b0);
                        if (page_left == 0) begin
                            emit_poll();
                            flash_step = STEP_STATUS;
                        end
                    end
                end
                default: ;
            endcase
        end
        if (result_q.size() > start_size) result_q[result_q.size() - 1].last = 1'b1;
        return result_q.size() - start_size;
    endfunction

    task automatic report_mismatch(string msg);
        err_count++;
        if (err_count <= 40) $display("MISMATCH @%0t: %s", $realtime, msg);
    endtask

    task automatic check_beat();
        t_flash_beat want;
        if (m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1) begin
            if (result_q.size() == 0) begin
                report_mismatch($sformatf("result beat kind %0d with nothing expected",
                                          m_axis_tuser));
            end else begin
                want = result_q.pop_front();
                if (m_axis_tuser !== want.kind || m_axis_tdata[7:0] !== want.spi ||
                    m_axis_tdata[8] !== want.fe || m_axis_tdata[9] !== want.wr ||
                    m_axis_tdata[17:10] !== want.host || m_axis_tdata[33:18] !== want.id ||
                    m_axis_tdata[39:34] !== 6'd0 || m_axis_tlast !== want.last) begin
                    report_mismatch($sformatf({"got/exp kind %0d/%0d spi %h/%h fe %b/%b",
                        " wr %b/%b host %h/%h id %h/%h fill %h last %b/%b"},
                        m_axis_tuser, want.kind, m_axis_tdata[7:0], want.spi,
                        m_axis_tdata[8], want.fe, m_axis_tdata[9], want.wr,
                        m_axis_tdata[17:10], want.host, m_axis_tdata[33:18], want.id,
                        m_axis_tdata[39:34], m_axis_tlast, want.last));
                end
            end
        end
    endtask

    task automatic tick();
        @(posedge i_clk);
        check_beat();
    endtask

    task automatic drive_request(input logic [2:0] rq, input logic [23:0] ad,
                                 input logic [23:0] ct, input logic [7:0] db,
                                 output int n_res);
        while (src_gap_pct > 0 && $urandom_range(99) < src_gap_pct) begin
            s_axis_tvalid <= 1'b0;
            tick();
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {db, ct, ad};
        s_axis_tuser  <= rq;
        do tick(); while (s_axis_tready !== 1'b1);
        n_res = predict_flash(rq, ad, ct, db);
    endtask

    // picks the next beat from the job in flight; clean gives only well-formed beats
    task automatic next_item(input bit clean, output logic [2:0] rq, output logic [23:0] ad,
                             output logic [23:0] ct, output logic [7:0] db);
        int pick;
        int sel;
        ad   = 24'($urandom);
        ct   = 24'($urandom);
        db   = 8'($urandom);
        pick = $urandom_range(99);
        if (flash_job == JOB_IDLE) begin
            if (!clean && pick < 15) begin
                case ($urandom_range(2))
                    0:       rq = REQ_REPLY;
                    1:       rq = REQ_DATA;
                    default: rq = $urandom_range(1) ? REQ_SPARE6 : REQ_SPARE7;
                endcase
            end else begin
                case ($urandom_range(3))
                    0: begin
                        rq = REQ_READ;
                        ct = ($urandom_range(7) == 0) ? 24'd0 : 24'($urandom_range(6, 1));
                    end
                    1: begin
                        rq  = REQ_PROG;
                        sel = $urandom_range(9);
                        if ($urandom_range(1)) ad[7:0] = 8'(256 - $urandom_range(8, 1));
                        ct = (sel == 0) ? 24'd0 :
                             (sel == 1) ? 24'($urandom_range(40, 25)) :
                                          24'($urandom_range(24, 1));
                    end
                    2: begin
                        rq = REQ_ERASE;
                        ct = ($urandom_range(9) == 0) ? 24'd0 : 24'($urandom_range(12288, 1));
                    end
                    default: rq = REQ_ID;
                endcase
            end
        end else if (!clean && pick < 10) begin
            case ($urandom_range(3))
                0:       rq = 3'($urandom_range(3));
                1:       rq = REQ_DATA;
                2:       rq = REQ_REPLY;
                default: rq = $urandom_range(1) ? REQ_SPARE6 : REQ_SPARE7;
            endcase
        end else if (flash_job == JOB_PROG && flash_step == STEP_DATA) begin
            rq = REQ_DATA;
        end else begin
            rq = REQ_REPLY;
            if (flash_job == JOB_PROG || flash_job == JOB_ERASE)
                db[0] = !clean && ($urandom_range(99) < 30);
        end
    endtask

    task automatic write_erase_op(input logic [7:0] v);
        s_axis_tvalid <= 1'b0;
        while (result_q.size() != 0) tick();
        repeat (4) tick();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do tick(); while (o_cfg_ready !== 1'b1);
        erase_op = v;
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        int          n;
        int          busy_items;
        logic [2:0]  rq;
        logic [23:0] ad;
        logic [23:0] ct;
        logic [7:0]  db;

        repeat (2) tick();
        i_rst_n <= 1'b1;

        for (int i = 0; i < N_DIR; i++) begin
            drive_request(dir_rows[i].req, dir_rows[i].addr, dir_rows[i].cnt,
                          dir_rows[i].data, n);
            if (dir_rows[i].typed) begin
                repeat (n) void'(result_q.pop_back());
                if (dir_rows[i].has_res) begin
                    emit(dir_rows[i].kind, 8'h00, 1'b0, 1'b0, 8'h00, 16'h0000);
                    result_q[result_q.size() - 1].last = 1'b1;
                end
            end
        end

        for (int ph = 0; ph < 4; ph++) begin
            if (ph == 1) write_erase_op(8'h00);
            if (ph == 2) write_erase_op(8'hFF);
            if (ph == 3) write_erase_op(8'($urandom));
            src_gap_pct   = (ph == 1) ? 73 : (ph == 3) ? 33 : 0;
            snk_stall_pct = (ph == 2) ? 73 : (ph == 3) ? 33 : 0;
            busy_items = 0;
            while (busy_items < BUSY_PER_PHASE) begin
                next_item(1'b0, rq, ad, ct, db);
                drive_request(rq, ad, ct, db, n);
                if (n > 0) busy_items++;
            end
            // finish the job in flight so the next register write lands while idle
            while (flash_job != JOB_IDLE) begin
                next_item(1'b1, rq, ad, ct, db);
                drive_request(rq, ad, ct, db, n);
            end
        end

        s_axis_tvalid <= 1'b0;
        while (result_q.size() != 0) tick();
        repeat (8) tick();
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
